/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// FNTW_ASSERT is off while reset is asserted; FNTW_ASSERT_RST also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FNTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define FNTW_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/fntw_pkg.sv */
// ----------------------------------------------------------------------------
// Fractional-N tuning word package
// Request and result types, pipeline stage record, constants and the
// per-stage arithmetic of the tuning word pipeline.
// ----------------------------------------------------------------------------
package fntw_pkg;

    // Field widths.
    localparam int FREQ_W   = 22;
    localparam int SR_W     = 26;
    localparam int REF_W    = 16;
    localparam int INT_W    = 9;
    localparam int FRAC_W   = 18;
    localparam int PUMP_W   = 3;
    localparam int FILT_W   = 6;
    localparam int FVCO_W   = 23;

    // Long division of fvco * 2^18 by the reference, four quotient bits per stage.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 11;
    localparam int NUM_W      = DIV_STEPS * DIV_STAGES;
    localparam int QUO_W      = INT_W + FRAC_W;
    localparam int REM_W      = REF_W;

    // One front stage followed by the division stages.
    localparam int NUM_STAGES = DIV_STAGES + 1;

    // Filter code arithmetic: symbol rate times 135 and its thresholds.
    localparam int PROD_W     = 34;
    localparam int FILT_STEPS = 44;
    localparam logic [63:0] MHZ    = 64'd1000000;
    localparam logic [63:0] SR_MUL = 64'd135;
    localparam logic [63:0] SR_DIV = 64'd200;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_REF_FREQ = 1'b0;
    localparam logic [REF_W-1:0] REF_FREQ_RESET = 16'd16000;

    // Prescaler band limit and charge pump band edges in kHz.
    localparam logic [FREQ_W-1:0] LOW_BAND_MAX_KHZ = 22'd1300000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_1 = 23'd2700000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_2 = 23'd2950000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_3 = 23'd3300000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_4 = 23'd3700000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_5 = 23'd4200000;
    localparam logic [FVCO_W-1:0] PUMP_EDGE_6 = 23'd4800000;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_khz;
        logic [SR_W-1:0]   sym_rate;
    } req_t;

    typedef struct packed {
        logic [INT_W-1:0]  int_divider;
        logic [FRAC_W-1:0] frac_divider;
        logic [PUMP_W-1:0] pump_current;
        logic              prescale_sel;
        logic [FILT_W-1:0] filter_code;
    } rsp_t;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [NUM_W-1:0]      num;
        logic [QUO_W-1:0]      quo;
        logic [FVCO_W-1:0]     fvco;
        logic                  psel;
        logic [PROD_W-1:0]     prod;
        logic [FILT_STEPS-1:0] thermo;
        logic [FILT_W-1:0]     filt;
        logic [PUMP_W-1:0]     pump;
    } pipe_t;

    // Front stage: prescaler choice, fvco, symbol rate product, divider seed.
    function automatic pipe_t front(req_t r);
        pipe_t p;
        p = '0;
        if (r.freq_khz <= LOW_BAND_MAX_KHZ) begin
            p.psel = 1'b1;
            p.fvco = FVCO_W'({r.freq_khz, 2'b00});
        end else begin
            p.psel = 1'b0;
            p.fvco = {r.freq_khz, 1'b0};
        end
        p.num  = NUM_W'({p.fvco, {FRAC_W{1'b0}}});
        p.prod = PROD_W'(r.sym_rate) * PROD_W'(SR_MUL);
        return p;
    endfunction

    // Restoring division steps of one stage.
    function automatic pipe_t div_stage(pipe_t p, logic [REF_W-1:0] rdiv);
        pipe_t o;
        logic [REM_W:0] t;
        o = p;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t     = {o.rem, o.num[NUM_W-1]};
            o.num = {o.num[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, rdiv}) begin
                o.rem = REM_W'(t - {1'b0, rdiv});
                o.quo = {o.quo[QUO_W-2:0], 1'b1};
            end else begin
                o.rem = t[REM_W-1:0];
                o.quo = {o.quo[QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Charge pump code from the fvco band; code 4 is skipped.
    function automatic logic [PUMP_W-1:0] pump_code(logic [FVCO_W-1:0] fvco);
        logic [PUMP_W-1:0] c;
        if (fvco < PUMP_EDGE_1) begin
            c = 3'd0;
        end else if (fvco < PUMP_EDGE_2) begin
            c = 3'd1;
        end else if (fvco < PUMP_EDGE_3) begin
            c = 3'd2;
        end else if (fvco < PUMP_EDGE_4) begin
            c = 3'd3;
        end else if (fvco < PUMP_EDGE_5) begin
            c = 3'd5;
        end else if (fvco < PUMP_EDGE_6) begin
            c = 3'd6;
        end else begin
            c = 3'd7;
        end
        return c;
    endfunction

    // Bit j is set when the cutoff rounds up past (j + 6) MHz, that is when
    // sym_rate * 135 >= 200 * ((j + 1) MHz + 1).
    function automatic logic [FILT_STEPS-1:0] thermo_of(logic [PROD_W-1:0] prod);
        logic [FILT_STEPS-1:0] t;
        for (int j = 0; j < FILT_STEPS; j++) begin
            t[j] = prod >= PROD_W'((64'(j) + 64'd1) * MHZ * SR_DIV + SR_DIV);
        end
        return t;
    endfunction

    // The thermometer code has a single edge; its position is the filter code.
    function automatic logic [FILT_W-1:0] therm_to_code(logic [FILT_STEPS-1:0] t);
        logic [FILT_W-1:0] c;
        c = '0;
        for (int j = 1; j < FILT_STEPS; j++) begin
            if (t[j-1] && !t[j]) begin
                c = c | FILT_W'(j);
            end
        end
        if (t[FILT_STEPS-1]) begin
            c = c | FILT_W'(FILT_STEPS);
        end
        return c;
    endfunction

endpackage

/* hdl/fractional_n_tuning_word.sv */
// ----------------------------------------------------------------------------
// Fractional-N tuning word
// Turns a carrier frequency and symbol rate into divider, charge pump,
// prescaler and baseband filter settings.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless back-pressure holds it, and
// returns the results in order. A 44-step restoring divider forms
// fvco * 2^18 / ref_freq_khz: a front stage picks the prescaler and forms
// fvco and the symbol rate product, then eleven stages each resolve four
// quotient bits. The charge pump and filter codes are worked out alongside in
// the first two division stages. Each stage holds its item until the next one
// frees up, so back-pressure on the result side fills bubbles before it stops
// the request side. ref_freq_khz (byte address 0) resets to 16000; the user
// must change it only while no request is in flight, as the block does not
// enforce this. A zero reference gives zero integer and fractional dividers.
module fractional_n_tuning_word (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fntw_pkg::req_t                    s_data,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output fntw_pkg::rsp_t                    m_data,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fntw_pkg::ADDR_W-1:0]       paddr,
    input  logic [fntw_pkg::APB_DW-1:0]       pwdata,
    output logic [fntw_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int NS = fntw_pkg::NUM_STAGES;

    logic [fntw_pkg::REF_W-1:0] ref_reg;
    logic [NS-1:0]              valid_reg;
    logic [NS-1:0]              valid_next;
    logic [NS:0]                stage_ready;
    logic [NS-1:0]              stage_load;
    fntw_pkg::pipe_t            stage_reg  [NS];
    fntw_pkg::pipe_t            stage_next [NS];
    logic                       reg_hit;

    // Register decode; the port never waits.
    assign pready  = 1'b1;
    assign reg_hit = paddr[fntw_pkg::ADDR_W-1:2] == fntw_pkg::REG_REF_FREQ;

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = fntw_pkg::APB_DW'(ref_reg);
        end
    end

    // Reference frequency register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= fntw_pkg::REF_FREQ_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            ref_reg <= pwdata[fntw_pkg::REF_W-1:0];
        end
    end

    // A stage takes a new item when it is empty or its successor takes its own.
    always_comb begin
        stage_ready[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                stage_load[k] = stage_ready[k] && s_valid;
                valid_next[k] = stage_ready[k] ? s_valid : valid_reg[k];
            end else begin
                stage_load[k] = stage_ready[k] && valid_reg[k-1];
                valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    end

    assign s_ready = stage_ready[0];

    // Stage arithmetic: front stage, then division with the side codes.
    always_comb begin
        stage_next[0] = fntw_pkg::front(s_data);
        for (int k = 1; k < NS; k++) begin
            stage_next[k] = fntw_pkg::div_stage(stage_reg[k-1], ref_reg);
        end
        stage_next[1].pump   = fntw_pkg::pump_code(stage_reg[0].fvco);
        stage_next[1].thermo = fntw_pkg::thermo_of(stage_reg[0].prod);
        stage_next[2].filt   = fntw_pkg::therm_to_code(stage_reg[1].thermo);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage data registers.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (stage_load[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Result from the last stage; a zero reference clears the divider fields.
    assign m_valid = valid_reg[NS-1];

    always_comb begin
        m_data.int_divider  = stage_reg[NS-1].quo[fntw_pkg::QUO_W-1:fntw_pkg::FRAC_W];
        m_data.frac_divider = stage_reg[NS-1].quo[fntw_pkg::FRAC_W-1:0];
        m_data.pump_current = stage_reg[NS-1].pump;
        m_data.prescale_sel = stage_reg[NS-1].psel;
        m_data.filter_code  = stage_reg[NS-1].filt;
        if (ref_reg == '0) begin
            m_data.int_divider  = '0;
            m_data.frac_divider = '0;
        end
    end

endmodule

/* hdl/fntw_checker.sv */
// ----------------------------------------------------------------------------
// Fractional-N tuning word checker
// Port-level checks of flow control and result codes, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fntw_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input fntw_pkg::rsp_t              m_data,
    input logic                        psel
);

    // Requests are refused only when the whole pipeline is backed up.
    `FNTW_ASSERT(a_refuse_only_when_full, !s_ready |-> m_valid && !m_ready, "refused too early")

    // A stalled result holds while the configuration is left alone.
    `FNTW_ASSERT(a_stalled_result_holds, m_valid && !m_ready && !psel |=> $stable(m_data), "stall moved")

    // The pump code skips 4 and the filter code stays in its clamped range.
    `FNTW_ASSERT(a_result_codes, m_valid |-> m_data.filter_code <= 6'd44, "filter code too big")
    `FNTW_ASSERT(a_pump_code, m_valid |-> m_data.pump_current != 3'd4, "pump code 4 seen")

    // Reset empties the pipeline.
    `FNTW_ASSERT_RST(a_reset_empties, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind fractional_n_tuning_word fntw_checker u_fntw_checker (.*);

/* test/tb_fractional_n_tuning_word.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N tuning word testbench
// Drives tuning requests through the valid/ready input with bursty timing.
// Applies random and long back-pressure on the result side. Moves the
// reference frequency through several settings between phases, including 0,
// 1 and 65535. Every result is checked field by field against a local
// calculation of the synthesizer settings.
// ----------------------------------------------------------------------------
module tb_fractional_n_tuning_word;

    localparam int  CLK_PERIOD     = 12;
    localparam int  RESET_CYCLES   = 12;
    localparam int  PIPE_LATENCY   = 12;
    localparam int  SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  WATCHDOG_LIMIT = 2500;
    localparam int  MAX_REPORTS    = 50;
    localparam int  NUM_PHASES     = 9;
    localparam int  NUM_DIRECTED   = 22;
    localparam logic [fntw_pkg::SR_W-1:0] SR_MAX = '1;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM_BUSY,
        RX_PERIODIC,
        RX_RANDOM_SPARSE
    } rx_mode_t;

    // Charge pump band edges in kHz of fvco and the code below each edge.
    localparam int unsigned PUMP_EDGE_KHZ [6] =
        '{2700000, 2950000, 3300000, 3700000, 4200000, 4800000};
    localparam logic [fntw_pkg::PUMP_W-1:0] PUMP_BAND_CODE [7] =
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};

    // Directed requests: field extremes, prescaler edge, pump band edges in
    // both bands, and the filter clamp edges.
    localparam logic [fntw_pkg::FREQ_W-1:0] DIRECTED_FREQ [NUM_DIRECTED] = '{
        22'd0, 22'd4194303, 22'd1300000, 22'd1300001, 22'd674999, 22'd675000,
        22'd737500, 22'd825000, 22'd924999, 22'd925000, 22'd1050000,
        22'd1200000, 22'd1349999, 22'd1350000, 22'd1475000, 22'd1650000,
        22'd1850000, 22'd2100000, 22'd2399999, 22'd2400000, 22'd16000,
        22'd3999999};
    localparam logic [fntw_pkg::SR_W-1:0] DIRECTED_SR [NUM_DIRECTED] = '{
        26'd0, 26'd67108863, 26'd1481482, 26'd1481483, 26'd65185186,
        26'd65185187, 26'd1, 26'd3000000, 26'd10000000, 26'd33554432,
        26'd45000000, 26'd60000000, 26'd2962965, 26'd7407407, 26'd20000000,
        26'd50000000, 26'd12345678, 26'd5000000, 26'd1481481, 26'd40000000,
        26'd25000000, 26'd67108862};

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    fntw_pkg::req_t                    s_data  = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    fntw_pkg::rsp_t                    m_data;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [fntw_pkg::ADDR_W-1:0]       paddr   = '0;
    logic [fntw_pkg::APB_DW-1:0]       pwdata  = '0;
    logic [fntw_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    fntw_pkg::req_t                    pending_reqs[$];
    fntw_pkg::rsp_t                    expected_words[$];
    logic [fntw_pkg::REF_W-1:0]        ref_khz_setting = fntw_pkg::REF_FREQ_RESET;
    int                                mismatches = 0;
    rx_mode_t                          rx_mode = RX_ALWAYS;
    int                                hold_reqs = 0;

    fractional_n_tuning_word DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Synthesizer settings for one request at the given reference frequency.
    function automatic fntw_pkg::rsp_t calc_tuning_word(fntw_pkg::req_t r,
                                                        logic [fntw_pkg::REF_W-1:0] ref_khz);
        fntw_pkg::rsp_t w;
        logic [63:0]    fvco;
        logic [63:0]    cutoff;
        logic [63:0]    mhz_up;
        w = '0;
        if (r.freq_khz <= 22'd1300000) begin
            w.prescale_sel = 1'b1;
            fvco = 64'(r.freq_khz) * 64'd4;
        end else begin
            w.prescale_sel = 1'b0;
            fvco = 64'(r.freq_khz) * 64'd2;
        end
        // A zero reference leaves both divider fields at zero.
        if (ref_khz != '0) begin
            w.int_divider  = fntw_pkg::INT_W'(fvco / 64'(ref_khz));
            w.frac_divider = fntw_pkg::FRAC_W'(
                ((fvco % 64'(ref_khz)) << fntw_pkg::FRAC_W) / 64'(ref_khz));
        end
        w.pump_current = PUMP_BAND_CODE[6];
        for (int b = 5; b >= 0; b--) begin
            if (fvco < 64'(PUMP_EDGE_KHZ[b])) begin
                w.pump_current = PUMP_BAND_CODE[b];
            end
        end
        // Filter cutoff rounded up to whole MHz, clamped to 6..50 MHz.
        cutoff = 64'd5000000 + (64'(r.sym_rate) * 64'd135) / 64'd200;
        mhz_up = (cutoff + 64'd999999) / 64'd1000000;
        if (mhz_up < 64'd6) begin
            mhz_up = 64'd6;
        end
        if (mhz_up > 64'd50) begin
            mhz_up = 64'd50;
        end
        w.filter_code = fntw_pkg::FILT_W'(mhz_up - 64'd6);
        return w;
    endfunction

    // Carrier frequency: full range, up to 100000 kHz, or close to the prescaler or pump edges.
    function automatic logic [fntw_pkg::FREQ_W-1:0] pick_freq();
        int unsigned f;
        int unsigned edge_khz;
        f = 0;
        edge_khz = PUMP_EDGE_KHZ[$urandom_range(0, 5)];
        case ($urandom_range(0, 5))
            0, 1: f = $urandom_range(0, 4194303);
            2:    f = 1300000 + $urandom_range(0, 16) - 8;
            3:    f = edge_khz / 4 + $urandom_range(0, 4) - 2;
            4:    f = edge_khz / 2 + $urandom_range(0, 4) - 2;
            default: f = $urandom_range(0, 100000);
        endcase
        return fntw_pkg::FREQ_W'(f);
    endfunction

    // Symbol rate: full range, up to 2000000, near the maximum, or close to a filter step.
    function automatic logic [fntw_pkg::SR_W-1:0] pick_sr();
        logic [63:0] s;
        s = '0;
        case ($urandom_range(0, 4))
            0, 1: s = 64'($urandom_range(0, 67108863));
            2: begin
                s = (64'($urandom_range(0, 46)) * 64'd200000000) / 64'd135
                    + 64'($urandom_range(0, 6));
                s = (s > 64'd3) ? s - 64'd3 : s;
            end
            3: s = 64'($urandom_range(0, 2000000));
            default: s = 64'(SR_MAX) - 64'($urandom_range(0, 3000000));
        endcase
        if (s > 64'(SR_MAX)) begin
            s = 64'(SR_MAX);
        end
        return fntw_pkg::SR_W'(s);
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            if (mismatches < MAX_REPORTS) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
            end
            mismatches++;
        end
    endtask

    // Configuration write, setup then access until pready, then a read back.
    task automatic write_ref_freq(input logic [fntw_pkg::REF_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fntw_pkg::ADDR_W'({fntw_pkg::REG_REF_FREQ, 2'b00});
        pwdata  <= fntw_pkg::APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ref_khz_setting = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("ref_freq_khz", 32'(value), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 64);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: a stall pattern per phase, and a long hold-off on request.
    int hold_seen = 0;
    int hold_left = 0;
    int rx_tick   = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            rx_tick = rx_tick + 1;
            case (rx_mode)
                RX_ALWAYS:        m_ready <= 1'b1;
                RX_RANDOM_BUSY:   m_ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC:      m_ready <= ((rx_tick % 7) > 2);
                RX_RANDOM_SPARSE: m_ready <= ($urandom_range(0, 9) < 3);
                default:          m_ready <= 1'b1;
            endcase
        end
    end

    // Result check first, then the prediction for a newly accepted request.
    fntw_pkg::rsp_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t ns: result expected none, got %h", $time, m_data);
                    end
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("int_divider", 32'(want.int_divider),
                                32'(m_data.int_divider));
                    check_field("frac_divider", 32'(want.frac_divider),
                                32'(m_data.frac_divider));
                    check_field("pump_current", 32'(want.pump_current),
                                32'(m_data.pump_current));
                    check_field("prescale_sel", 32'(want.prescale_sel),
                                32'(m_data.prescale_sel));
                    check_field("filter_code", 32'(want.filter_code),
                                32'(m_data.filter_code));
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(calc_tuning_word(s_data, ref_khz_setting));
            end
        end
    end

    // Ends the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Phase sequence: reference setting, stall pattern and request load.
    initial begin : sequencer
        int                         n_items;
        logic [fntw_pkg::REF_W-1:0] next_ref;
        fntw_pkg::req_t             r;
        n_items  = 0;
        next_ref = fntw_pkg::REF_FREQ_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Configuration changes only once the pipeline has drained.
            case (ph)
                0: begin next_ref = fntw_pkg::REF_FREQ_RESET; n_items = 250; end
                1: begin next_ref = 16'd1;          n_items = 150; end
                2: begin next_ref = 16'd65535;      n_items = 200; end
                3: begin next_ref = 16'd0;          n_items = 150; end
                4: begin next_ref = 16'd3;          n_items = 150; end
                5: begin next_ref = 16'd27000;      n_items = 200; end
                6: begin
                    next_ref = fntw_pkg::REF_W'($urandom_range(1, 65535));
                    n_items  = 150;
                end
                7: begin
                    next_ref = fntw_pkg::REF_W'($urandom_range(2, 50));
                    n_items  = 100;
                end
                default: begin next_ref = fntw_pkg::REF_FREQ_RESET; n_items = 100; end
            endcase
            if (ph != 0) begin
                write_ref_freq(next_ref);
            end
            rx_mode = rx_mode_t'(ph % 4);

            if (ph == 0) begin
                for (int i = 0; i < NUM_DIRECTED; i++) begin
                    r.freq_khz = DIRECTED_FREQ[i];
                    r.sym_rate = DIRECTED_SR[i];
                    pending_reqs.push_back(r);
                end
            end
            for (int i = 0; i < n_items; i++) begin
                r.freq_khz = pick_freq();
                r.sym_rate = pick_sr();
                pending_reqs.push_back(r);
            end
            // Long back-pressure while the sender still has requests to offer.
            if (ph == 2) begin
                hold_reqs = hold_reqs + 1;
            end

            // Sampled away from the rising edge so that every update of the
            // driver and the monitor at that edge is already visible.
            while (pending_reqs.size() != 0 || s_valid || expected_words.size() != 0) begin
                @(negedge aclk);
            end
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/fntw_pkg.sv
hdl/fractional_n_tuning_word.sv
hdl/fntw_checker.sv
test/tb_fractional_n_tuning_word.sv
